@@ rtl/sasi_pkg.sv @@
package sasi_pkg;

    localparam int AXES      = 6;
    localparam int DUTY_W    = 14;
    localparam int STEP_W    = 15;
    localparam int AXIS_W    = 3;
    localparam int PERIOD_W  = 10;
    localparam int GRIPMS_W  = 15;
    localparam int DUR_W     = 16;
    localparam int PROD_W    = DUTY_W + STEP_W;
    localparam int DIVIDEND_W = 2 * STEP_W;
    localparam int DIV_STEPS = STEP_W;
    localparam int CNT_W     = 4;

    localparam logic [DUTY_W-1:0]   DUTY_MAX     = 14'd10000;
    localparam logic [PERIOD_W-1:0] TICK_RESET   = 10'd20;
    localparam logic [GRIPMS_W-1:0] GRIPMS_RESET = 15'd300;
    localparam logic [AXIS_W-1:0]   GRIP_AXIS    = 3'd5;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_MOVE = 2'd1;
    localparam logic [1:0] CMD_JUMP = 2'd2;

    localparam logic CFG_TICK_PERIOD = 1'b0;
    localparam logic CFG_GRIP_MS     = 1'b1;

    typedef enum logic [1:0] {
        JOB_LERP,
        JOB_TOTAL,
        JOB_GRIP
    } job_t;

    typedef struct packed {
        logic               capture;
        logic               mul_load;
        logic               div_step;
        logic               wb;
        logic               exec;
        logic               out_load;
        job_t               job;
        logic [AXIS_W-1:0]  axis;
    } ctrl_cmd_t;

    typedef struct packed {
        logic busy;
        logic last;
        logic out_free;
    } dp_status_t;

    function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] v);
        sat_duty = (v > DUTY_MAX) ? DUTY_MAX : v;
    endfunction

endpackage

@@ rtl/sasi_ctrl.sv @@
module sasi_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            in_command,
    output logic                  in_stall,
    output sasi_pkg::ctrl_cmd_t   cmd,
    input  sasi_pkg::dp_status_t  status
);
    import sasi_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_DIV  = 6'b000100,
        S_WB   = 6'b001000,
        S_EXEC = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    job_t               job_reg, job_next;
    logic [AXIS_W-1:0]  axis_reg, axis_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.job    = job_reg;
        cmd.axis   = axis_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    axis_next   = '0;
                    if (in_command == CMD_MOVE)
                    begin
                        job_next   = JOB_TOTAL;
                        state_next = S_MUL;
                    end
                    else if (in_command == CMD_TICK && status.busy && !status.last)
                    begin
                        job_next   = JOB_LERP;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = S_WB;
            end
            S_WB:
            begin
                cmd.wb = 1'b1;
                case (job_reg)
                    JOB_TOTAL:
                    begin
                        job_next   = JOB_GRIP;
                        state_next = S_MUL;
                    end
                    JOB_LERP:
                    begin
                        if (axis_reg == GRIP_AXIS)
                            state_next = S_EXEC;
                        else
                        begin
                            axis_next  = axis_reg + AXIS_W'(1);
                            state_next = S_MUL;
                        end
                    end
                    default:
                        state_next = S_EXEC;
                endcase
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= JOB_LERP;
            axis_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ rtl/sasi_datapath.sv @@
module sasi_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sasi_pkg::ctrl_cmd_t               cmd,
    output sasi_pkg::dp_status_t              status,
    input  logic [1:0]                        command,
    input  logic [sasi_pkg::DUTY_W-1:0]       target_base,
    input  logic [sasi_pkg::DUTY_W-1:0]       target_upper_arm,
    input  logic [sasi_pkg::DUTY_W-1:0]       target_middle_arm,
    input  logic [sasi_pkg::DUTY_W-1:0]       target_forearm,
    input  logic [sasi_pkg::DUTY_W-1:0]       target_wrist,
    input  logic [sasi_pkg::DUTY_W-1:0]       target_grip,
    input  logic signed [sasi_pkg::DUR_W-1:0] duration_ms,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [15:0]                       cfg_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sasi_pkg::DUTY_W-1:0]       pos_base,
    output logic [sasi_pkg::DUTY_W-1:0]       pos_upper_arm,
    output logic [sasi_pkg::DUTY_W-1:0]       pos_middle_arm,
    output logic [sasi_pkg::DUTY_W-1:0]       pos_forearm,
    output logic [sasi_pkg::DUTY_W-1:0]       pos_wrist,
    output logic [sasi_pkg::DUTY_W-1:0]       pos_gripper,
    output logic                              moving,
    output logic                              move_done
);
    import sasi_pkg::*;

    logic [PERIOD_W-1:0]   tick_period_reg;
    logic [GRIPMS_W-1:0]   grip_ms_reg;
    logic [DUTY_W-1:0]     joint_reg [AXES];
    logic [DUTY_W-1:0]     start_reg [AXES];
    logic [DUTY_W-1:0]     goal_reg  [AXES];
    logic [DUTY_W-1:0]     tgt_reg   [AXES];
    logic [DUTY_W-1:0]     tgt_in    [AXES];
    logic [DUTY_W-1:0]     pos_reg   [AXES];
    logic [1:0]            cmd_reg;
    logic [DUR_W-1:0]      dur_reg;
    logic [STEP_W-1:0]     idx_reg, total_reg, grip_reg;
    logic [STEP_W-1:0]     tot_q_reg, grp_q_reg;
    logic                  busy_reg, done_reg, out_valid_reg, moving_reg, out_done_reg;
    logic [STEP_W-1:0]     rem_reg, q_reg;
    logic                  neg_reg;

    logic [STEP_W-1:0]     k_w, divisor_w, tot_fix, grp_fix, grp_final;
    logic [PERIOD_W-1:0]   period_w;
    logic [DUTY_W:0]       diff_w, mag_full;
    logic [PROD_W-1:0]     prod_w;
    logic [DIVIDEND_W-1:0] dividend_w;
    logic [STEP_W:0]       trial_w, sub_w;
    logic                  ge_w, draw_pos;
    logic [DUTY_W-1:0]     lerp_w;

    assign tgt_in[0] = target_base;
    assign tgt_in[1] = target_upper_arm;
    assign tgt_in[2] = target_middle_arm;
    assign tgt_in[3] = target_forearm;
    assign tgt_in[4] = target_wrist;
    assign tgt_in[5] = target_grip;

    always_comb
    begin
        k_w      = idx_reg + STEP_W'(1);
        period_w = (tick_period_reg == '0) ? PERIOD_W'(1) : tick_period_reg;
        diff_w   = {1'b0, goal_reg[cmd.axis]} - {1'b0, start_reg[cmd.axis]};
        mag_full = diff_w[DUTY_W] ? (~diff_w + (DUTY_W+1)'(1)) : diff_w;
        prod_w   = {{STEP_W{1'b0}}, mag_full[DUTY_W-1:0]} * {{DUTY_W{1'b0}}, k_w};
        case (cmd.job)
            JOB_LERP:
            begin
                dividend_w = {1'b0, prod_w};
                divisor_w  = (cmd.axis == GRIP_AXIS) ? grip_reg : total_reg;
            end
            JOB_TOTAL:
            begin
                dividend_w = {{(DIVIDEND_W-STEP_W){1'b0}}, dur_reg[STEP_W-1:0]};
                divisor_w  = {{(STEP_W-PERIOD_W){1'b0}}, period_w};
            end
            default:
            begin
                dividend_w = {{(DIVIDEND_W-GRIPMS_W){1'b0}}, grip_ms_reg};
                divisor_w  = {{(STEP_W-PERIOD_W){1'b0}}, period_w};
            end
        endcase
        // restoring division, one quotient bit a cycle
        trial_w = {rem_reg, q_reg[STEP_W-1]};
        ge_w    = trial_w >= {1'b0, divisor_w};
        sub_w   = trial_w - {1'b0, divisor_w};
        if (neg_reg)
            lerp_w = start_reg[cmd.axis] - q_reg[DUTY_W-1:0];
        else
            lerp_w = start_reg[cmd.axis] + q_reg[DUTY_W-1:0];
        draw_pos  = !dur_reg[DUR_W-1] && (dur_reg != '0);
        tot_fix   = (draw_pos && tot_q_reg != '0) ? tot_q_reg : STEP_W'(1);
        grp_fix   = (grp_q_reg == '0) ? STEP_W'(1) : grp_q_reg;
        grp_final = (grp_fix > tot_fix) ? tot_fix : grp_fix;
    end

    assign status.busy     = busy_reg;
    assign status.last     = k_w >= total_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= TICK_RESET;
            grip_ms_reg     <= GRIPMS_RESET;
            idx_reg         <= '0;
            total_reg       <= STEP_W'(1);
            grip_reg        <= STEP_W'(1);
            busy_reg        <= 1'b0;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < AXES; i++)
                joint_reg[i] <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_TICK_PERIOD)
                    tick_period_reg <= cfg_data[PERIOD_W-1:0];
                else
                    grip_ms_reg <= cfg_data[GRIPMS_W-1:0];
            end
            if (cmd.wb && cmd.job == JOB_LERP)
            begin
                if (cmd.axis == GRIP_AXIS && k_w > grip_reg)
                    joint_reg[cmd.axis] <= goal_reg[cmd.axis];
                else
                    joint_reg[cmd.axis] <= lerp_w;
            end
            if (cmd.exec)
            begin
                done_reg <= 1'b0;
                case (cmd_reg)
                    CMD_TICK:
                    begin
                        if (busy_reg)
                        begin
                            idx_reg <= k_w;
                            if (status.last)
                            begin
                                for (int i = 0; i < AXES; i++)
                                    joint_reg[i] <= goal_reg[i];
                                busy_reg <= 1'b0;
                                done_reg <= 1'b1;
                            end
                        end
                    end
                    CMD_MOVE:
                    begin
                        total_reg <= tot_fix;
                        grip_reg  <= grp_final;
                        idx_reg   <= '0;
                        busy_reg  <= 1'b1;
                    end
                    CMD_JUMP:
                    begin
                        for (int i = 0; i < AXES; i++)
                            joint_reg[i] <= tgt_reg[i];
                        idx_reg  <= '0;
                        busy_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= command;
            dur_reg <= duration_ms;
            for (int i = 0; i < AXES; i++)
                tgt_reg[i] <= sat_duty(tgt_in[i]);
        end
        if (cmd.mul_load)
        begin
            rem_reg <= dividend_w[DIVIDEND_W-1:STEP_W];
            q_reg   <= dividend_w[STEP_W-1:0];
            neg_reg <= (cmd.job == JOB_LERP) && diff_w[DUTY_W];
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge_w ? sub_w[STEP_W-1:0] : trial_w[STEP_W-1:0];
            q_reg   <= {q_reg[STEP_W-2:0], ge_w};
        end
        if (cmd.wb)
        begin
            if (cmd.job == JOB_TOTAL)
                tot_q_reg <= q_reg;
            if (cmd.job == JOB_GRIP)
                grp_q_reg <= q_reg;
        end
        if (cmd.exec && cmd_reg == CMD_MOVE)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                start_reg[i] <= joint_reg[i];
                goal_reg[i]  <= tgt_reg[i];
            end
        end
        if (cmd.out_load)
        begin
            for (int i = 0; i < AXES; i++)
                pos_reg[i] <= joint_reg[i];
            moving_reg   <= busy_reg;
            out_done_reg <= done_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pos_base       = pos_reg[0];
    assign pos_upper_arm  = pos_reg[1];
    assign pos_middle_arm = pos_reg[2];
    assign pos_forearm    = pos_reg[3];
    assign pos_wrist      = pos_reg[4];
    assign pos_gripper    = pos_reg[5];
    assign moving         = moving_reg;
    assign move_done      = out_done_reg;

endmodule

@@ rtl/six_axis_servo_interpolator_core.sv @@
// Six-axis linear servo interpolator. Every request gives exactly one result:
// the six joint duties after it, a moving flag and a move-done flag. A tick
// during a move that is not its final step runs each axis in turn through
// one multiply and a shared restoring divider. A move start runs two
// divisions by the tick period; a final tick, a jump, an idle tick and the
// unused code skip the divider. The block takes a new request as soon as
// the result of the last one sits in the output register, even while that
// result is still stalled.
module six_axis_servo_interpolator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        command,
    input  logic [sasi_pkg::DUTY_W-1:0]       target_base,
    input  logic [sasi_pkg::DUTY_W-1:0]       target_upper_arm,
    input  logic [sasi_pkg::DUTY_W-1:0]       target_middle_arm,
    input  logic [sasi_pkg::DUTY_W-1:0]       target_forearm,
    input  logic [sasi_pkg::DUTY_W-1:0]       target_wrist,
    input  logic [sasi_pkg::DUTY_W-1:0]       target_grip,
    input  logic signed [sasi_pkg::DUR_W-1:0] duration_ms,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sasi_pkg::DUTY_W-1:0]       pos_base,
    output logic [sasi_pkg::DUTY_W-1:0]       pos_upper_arm,
    output logic [sasi_pkg::DUTY_W-1:0]       pos_middle_arm,
    output logic [sasi_pkg::DUTY_W-1:0]       pos_forearm,
    output logic [sasi_pkg::DUTY_W-1:0]       pos_wrist,
    output logic [sasi_pkg::DUTY_W-1:0]       pos_gripper,
    output logic                              moving,
    output logic                              move_done,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [15:0]                       cfg_data
);
    import sasi_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    sasi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (command),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .status     (status)
    );

    sasi_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .command           (command),
        .target_base       (target_base),
        .target_upper_arm  (target_upper_arm),
        .target_middle_arm (target_middle_arm),
        .target_forearm    (target_forearm),
        .target_wrist      (target_wrist),
        .target_grip       (target_grip),
        .duration_ms       (duration_ms),
        .cfg_write         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .pos_base          (pos_base),
        .pos_upper_arm     (pos_upper_arm),
        .pos_middle_arm    (pos_middle_arm),
        .pos_forearm       (pos_forearm),
        .pos_wrist         (pos_wrist),
        .pos_gripper       (pos_gripper),
        .moving            (moving),
        .move_done         (move_done)
    );

endmodule

@@ rtl/sasi_checker.sv @@
module sasi_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [sasi_pkg::DUTY_W-1:0] pos_base,
    input logic [sasi_pkg::DUTY_W-1:0] pos_gripper,
    input logic                        moving,
    input logic                        move_done
);
    import sasi_pkg::*;

    // an accepted request always raises in_stall in the cycle after it
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted without holding off the next");

    a_done_not_moving: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(move_done && moving))
        else $error("move done while still moving");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pos_base <= DUTY_MAX) && (pos_gripper <= DUTY_MAX))
        else $error("duty out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pos_base) && $stable(moving))
        else $error("stalled result changed");

endmodule

bind six_axis_servo_interpolator_core sasi_checker u_sasi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pos_base    (pos_base),
    .pos_gripper (pos_gripper),
    .moving      (moving),
    .move_done   (move_done)
);

@@ tb/tb_six_axis_servo_interpolator_core.sv @@
`timescale 1ns / 100ps

module tb_six_axis_servo_interpolator_core;
    import sasi_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct packed {
        logic [AXES-1:0][DUTY_W-1:0] pos;
        logic                        moving;
        logic                        done;
    } pose_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] command;
    logic [DUTY_W-1:0] target_base, target_upper_arm, target_middle_arm;
    logic [DUTY_W-1:0] target_forearm, target_wrist, target_grip;
    logic signed [DUR_W-1:0] duration_ms;
    logic out_valid;
    logic out_stall;
    logic [DUTY_W-1:0] pos_base, pos_upper_arm, pos_middle_arm;
    logic [DUTY_W-1:0] pos_forearm, pos_wrist, pos_gripper;
    logic moving;
    logic move_done;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [15:0] cfg_data;

    six_axis_servo_interpolator_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .command(command),
        .target_base(target_base), .target_upper_arm(target_upper_arm),
        .target_middle_arm(target_middle_arm), .target_forearm(target_forearm),
        .target_wrist(target_wrist), .target_grip(target_grip),
        .duration_ms(duration_ms),
        .out_valid(out_valid), .out_stall(out_stall),
        .pos_base(pos_base), .pos_upper_arm(pos_upper_arm),
        .pos_middle_arm(pos_middle_arm), .pos_forearm(pos_forearm),
        .pos_wrist(pos_wrist), .pos_gripper(pos_gripper),
        .moving(moving), .move_done(move_done),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // joint state mirrored from the block
    int   joint[AXES];
    int   origin[AXES];
    int   goal[AXES];
    int   step_idx;
    int   step_tot;
    int   grip_tot;
    bit   busy;
    int   period_ms;
    int   grip_ms;

    pose_t pose_q[$];
    int    n_errors;
    int    n_requests;
    int    n_results;
    int    n_moves;
    int    n_arrivals;
    int    cycles;
    bit    gaps_on;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report(input string what);
        n_errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic int sat_target(input logic [DUTY_W-1:0] v);
        return (v > 10000) ? 10000 : int'(v);
    endfunction

    function automatic int lerp_axis(input int from, input int to, input int k,
                                     input int steps);
        longint diff;
        longint off;
        diff = longint'(to) - longint'(from);
        off  = (diff * k) / steps;
        return int'(from + off);
    endfunction

    task automatic predict_pose(input logic [1:0] cmd,
                                input logic [AXES-1:0][DUTY_W-1:0] tgt,
                                input logic [DUR_W-1:0] dur);
        pose_t p;
        bit    done;
        int    per;
        int    total;
        int    grip;
        done = 1'b0;
        case (cmd)
            CMD_TICK:
                if (busy)
                begin
                    step_idx++;
                    if (step_idx >= step_tot)
                    begin
                        for (int i = 0; i < AXES; i++) joint[i] = goal[i];
                        busy = 1'b0;
                        done = 1'b1;
                        n_arrivals++;
                    end
                    else
                    begin
                        for (int i = 0; i < AXES - 1; i++)
                            joint[i] = lerp_axis(origin[i], goal[i], step_idx, step_tot);
                        if (step_idx <= grip_tot)
                            joint[AXES-1] = lerp_axis(origin[AXES-1], goal[AXES-1],
                                                      step_idx, grip_tot);
                        else
                            joint[AXES-1] = goal[AXES-1];
                    end
                end
            CMD_MOVE:
            begin
                per   = (period_ms == 0) ? 1 : period_ms;
                total = 1;
                if (!dur[DUR_W-1] && dur != 0)
                begin
                    total = int'(dur) / per;
                    if (total == 0) total = 1;
                end
                grip = grip_ms / per;
                if (grip == 0) grip = 1;
                if (grip > total) grip = total;
                for (int i = 0; i < AXES; i++)
                begin
                    origin[i] = joint[i];
                    goal[i]   = sat_target(tgt[i]);
                end
                step_tot = total;
                grip_tot = grip;
                step_idx = 0;
                busy     = 1'b1;
                n_moves++;
            end
            CMD_JUMP:
            begin
                for (int i = 0; i < AXES; i++) joint[i] = sat_target(tgt[i]);
                step_idx = 0;
                busy     = 1'b0;
            end
            default: ;
        endcase
        for (int i = 0; i < AXES; i++) p.pos[i] = joint[i][DUTY_W-1:0];
        p.moving = busy;
        p.done   = done;
        pose_q.push_back(p);
    endtask

    // sender: random gaps, payload held while stalled
    task automatic send_request(input logic [1:0] cmd,
                                input logic [AXES-1:0][DUTY_W-1:0] tgt,
                                input logic [DUR_W-1:0] dur);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid          = 1'b1;
        command           = cmd;
        target_base       = tgt[0];
        target_upper_arm  = tgt[1];
        target_middle_arm = tgt[2];
        target_forearm    = tgt[3];
        target_wrist      = tgt[4];
        target_grip       = tgt[5];
        duration_ms       = dur;
        do @(posedge clk); while (in_stall);
        predict_pose(cmd, tgt, dur);
        n_requests++;
    endtask

    task automatic end_requests();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_idle();
        end_requests();
        wait (pose_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_TICK_PERIOD)
            period_ms = int'(data[PERIOD_W-1:0]);
        else
            grip_ms = int'(data[GRIPMS_W-1:0]);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // receiver: stall bursts and checking against the oldest prediction
    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (gaps_on && $urandom_range(0, 5) == 0)
                hold = $urandom_range(1, 15);
            out_stall = (hold > 0);
        end
    end

    always @(posedge clk)
    begin
        pose_t want;
        logic [AXES-1:0][DUTY_W-1:0] got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {pos_gripper, pos_wrist, pos_forearm, pos_middle_arm,
                   pos_upper_arm, pos_base};
            n_results++;
            if (pose_q.size() == 0)
                report("result with no request outstanding");
            else
            begin
                want = pose_q.pop_front();
                for (int i = 0; i < AXES; i++)
                    if (got[i] !== want.pos[i])
                        report($sformatf("axis %0d got %0d want %0d", i, got[i],
                                         want.pos[i]));
                if (moving !== want.moving)
                    report($sformatf("moving got %b want %b", moving, want.moving));
                if (move_done !== want.done)
                    report($sformatf("move_done got %b want %b", move_done, want.done));
            end
        end
    end

    function automatic logic [DUTY_W-1:0] rand_target();
        case ($urandom_range(0, 9))
            0:       return 14'd0;
            1:       return 14'd10000;
            2, 3:    return DUTY_W'($urandom_range(0, 16383));
            default: return DUTY_W'($urandom_range(0, 10000));
        endcase
    endfunction

    function automatic logic [AXES-1:0][DUTY_W-1:0] rand_pose();
        logic [AXES-1:0][DUTY_W-1:0] t;
        for (int i = 0; i < AXES; i++) t[i] = rand_target();
        return t;
    endfunction

    function automatic logic [AXES-1:0][DUTY_W-1:0] flat_pose(input int v);
        logic [AXES-1:0][DUTY_W-1:0] t;
        for (int i = 0; i < AXES; i++) t[i] = DUTY_W'(v);
        return t;
    endfunction

    task automatic tick();
        send_request(CMD_TICK, rand_pose(), DUR_W'($urandom));
    endtask

    task automatic test_idle_and_unused();
        tick();
        send_request(CMD_UNUSED, rand_pose(), 16'h7FFF);
        send_request(CMD_TICK, flat_pose(16383), 16'hFFFF);
    endtask

    task automatic test_jump_extremes();
        send_request(CMD_JUMP, flat_pose(16383), 16'h0000);
        send_request(CMD_JUMP, flat_pose(10001), 16'h8000);
        send_request(CMD_JUMP, flat_pose(0), 16'h1234);
        send_request(CMD_JUMP, flat_pose(10000), 16'h0000);
    endtask

    task automatic test_move_to_end();
        // default period 20: five steps, gripper capped to five
        send_request(CMD_MOVE, flat_pose(0), 16'sd100);
        repeat (6) tick();
        send_request(CMD_UNUSED, rand_pose(), 16'h0000);
    endtask

    task automatic test_move_special();
        send_request(CMD_MOVE, flat_pose(16383), 16'h8000);
        tick();
        send_request(CMD_MOVE, flat_pose(0), 16'h0000);
        tick();
        send_request(CMD_MOVE, rand_pose(), 16'sd400);
        tick();
        tick();
        // restart mid move, then jump cancels the second
        send_request(CMD_MOVE, rand_pose(), 16'sd200);
        tick();
        send_request(CMD_UNUSED, rand_pose(), 16'h0000);
        send_request(CMD_JUMP, rand_pose(), 16'sd200);
        tick();
    endtask

    task automatic run_random(input int n_items);
        int per;
        int steps;
        int sent;
        logic [DUR_W-1:0] dur;
        sent = 0;
        per  = (period_ms == 0) ? 1 : period_ms;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                steps = $urandom_range(1, 12);
                dur = DUR_W'(per * steps + $urandom_range(0, per - 1));
                if (per * steps > 32767) dur = 16'sd32767;
                if ($urandom_range(0, 15) == 0)
                    dur = DUR_W'(-$urandom_range(0, 32768));
                send_request(CMD_MOVE, rand_pose(), dur);
                sent++;
                steps = steps + $urandom_range(0, 2);
                for (int s = 0; s < steps && sent < n_items; s++)
                begin
                    if ($urandom_range(0, 30) == 0) break;
                    tick();
                    sent++;
                end
            end
            else
            begin
                send_request(2'($urandom_range(0, 3)), rand_pose(), DUR_W'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_random_phase(input logic [15:0] period_val,
                                     input logic [15:0] grip_val,
                                     input int n_items);
        write_reg(CFG_TICK_PERIOD, period_val);
        write_reg(CFG_GRIP_MS, grip_val);
        run_random(n_items);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_TICK;
        target_base = '0;
        target_upper_arm = '0;
        target_middle_arm = '0;
        target_forearm = '0;
        target_wrist = '0;
        target_grip = '0;
        duration_ms = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TICK_PERIOD;
        cfg_data = '0;
        gaps_on = 1'b1;
        period_ms = 20;
        grip_ms = 300;
        busy = 1'b0;
        step_idx = 0;
        step_tot = 1;
        grip_tot = 1;
        for (int i = 0; i < AXES; i++)
        begin
            joint[i] = 0;
            origin[i] = 0;
            goal[i] = 0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_and_unused();
        test_jump_extremes();
        test_move_to_end();
        test_move_special();

        test_random_phase(16'd20, 16'd300, 170);
        test_random_phase(16'd0, 16'd0, 170);
        test_random_phase(16'hFFFF, 16'hFFFF, 170);
        test_random_phase(16'd5, 16'd15, 170);
        test_random_phase(16'd1000, 16'd32767, 60);
        gaps_on = 1'b0;
        test_random_phase(16'd1, 16'd4, 110);

        wait_idle();
        $display("Sent %0d requests, checked %0d results: %0d moves, %0d reached target",
                 n_requests, n_results, n_moves, n_arrivals);
        $display("Tick periods 0, 1, 5, 20, 1000, 1023 with gripper times 0 to 32767");
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
